FILE: design/pwtd_pkg.sv
`default_nettype none

package pwtd_pkg;

   // Field widths of the channels.
   localparam int TS_W       = 16;
   localparam int PW_W       = 16;
   localparam int FREQ_W     = 16;
   localparam int CMP_W      = 8;
   localparam int WRAP_W     = 16;
   localparam int SCALE_W    = 32;
   localparam int NUM_W      = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Datapath sizing that does not depend on the counter width.
   localparam int CHUNK_W    = 16;
   localparam int DVD_W      = 32;
   localparam int DVS_W      = 16;
   localparam int DIV_STEPS  = DVD_W / 2;
   localparam int CNT_W      = 4;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_LOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_HIGH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_MIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_MAX  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_SCALE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIV_NUM    = 3'd5;

   // Register reset values.
   localparam logic [FREQ_W-1:0]  RST_FREQ_LOW   = 16'd1047;
   localparam logic [FREQ_W-1:0]  RST_FREQ_HIGH  = 16'd2093;
   localparam logic [PW_W-1:0]    RST_WIDTH_MIN  = 16'd95;
   localparam logic [PW_W-1:0]    RST_WIDTH_MAX  = 16'd827;
   localparam logic [SCALE_W-1:0] RST_TICK_SCALE = 32'd17180;
   localparam logic [NUM_W-1:0]   RST_DIV_NUM    = 24'd125000;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic item_load;
      logic mul_step;
      logic pw_load;
      logic map_load;
      logic div_load_map;
      logic div_load_cmp;
      logic div_step;
      logic freq_load;
      logic out_load;
   } pwtd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic end_edge;
   } pwtd_sts_type;

endpackage

`default_nettype wire

FILE: design/pwtd_if.sv
`default_nettype none

interface pwtd_req_if import pwtd_pkg::*;;
   logic            valid;
   logic            ready;
   logic            cmd;
   logic [TS_W-1:0] timestamp;

   modport source(output valid, cmd, timestamp, input ready);
   modport sink(input valid, cmd, timestamp, output ready);
endinterface

interface pwtd_rsp_if import pwtd_pkg::*;;
   logic              valid;
   logic              ready;
   logic [PW_W-1:0]   meas_width;
   logic [FREQ_W-1:0] tone_freq;
   logic [CMP_W-1:0]  compare_value;
   logic              status;

   modport source(output valid, meas_width, tone_freq, compare_value, status, input ready);
   modport sink(input valid, meas_width, tone_freq, compare_value, status, output ready);
endinterface

interface pwtd_csr_if import pwtd_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/pwtd_ctrl.sv
`default_nettype none

module pwtd_ctrl import pwtd_pkg::*; #(
   parameter int MUL_STEPS = 2
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   input  wire pwtd_sts_type sts,
   output pwtd_cmd_type      cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_PW,
      S_MAP,
      S_LOAD_MAP,
      S_DIV_MAP,
      S_FREQ,
      S_LOAD_CMP,
      S_DIV_CMP,
      S_OUT
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             rsp_valid_ff;
   logic             mul_last;
   logic             div_last;
   logic             out_free;

   assign mul_last  = (cnt_ff == CNT_W'(MUL_STEPS - 1));
   assign div_last  = (cnt_ff == CNT_W'(DIV_STEPS - 1));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd              = '0;
      cmd.item_load    = (state_ff == S_IDLE) && req_valid;
      cmd.mul_step     = (state_ff == S_MUL);
      cmd.pw_load      = (state_ff == S_PW);
      cmd.map_load     = (state_ff == S_MAP);
      cmd.div_load_map = (state_ff == S_LOAD_MAP);
      cmd.div_load_cmp = (state_ff == S_LOAD_CMP);
      cmd.div_step     = (state_ff == S_DIV_MAP) || (state_ff == S_DIV_CMP);
      cmd.freq_load    = (state_ff == S_FREQ);
      cmd.out_load     = (state_ff == S_OUT) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               cnt_ff <= '0;
               if (req_valid && sts.end_edge) begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               if (mul_last) begin
                  cnt_ff   <= '0;
                  state_ff <= S_PW;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_PW:       state_ff <= S_MAP;
            S_MAP:      state_ff <= S_LOAD_MAP;
            S_LOAD_MAP: state_ff <= S_DIV_MAP;
            S_DIV_MAP: begin
               if (div_last) begin
                  cnt_ff   <= '0;
                  state_ff <= S_FREQ;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_FREQ:     state_ff <= S_LOAD_CMP;
            S_LOAD_CMP: state_ff <= S_DIV_CMP;
            S_DIV_CMP: begin
               if (div_last) begin
                  cnt_ff   <= '0;
                  state_ff <= S_OUT;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: design/pwtd_datapath.sv
`default_nettype none

module pwtd_datapath import pwtd_pkg::*; #(
   parameter int COUNTER_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_cmd,
   input  wire logic [TS_W-1:0]       req_timestamp,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire pwtd_cmd_type          cmd,
   output pwtd_sts_type               sts,
   output logic [PW_W-1:0]            rsp_meas_width,
   output logic [FREQ_W-1:0]          rsp_tone_freq,
   output logic [CMP_W-1:0]           rsp_compare_value,
   output logic                       rsp_status
);

   localparam int TSU_W     = (COUNTER_BITS < TS_W) ? COUNTER_BITS : TS_W;
   localparam int TOT_W     = WRAP_W + COUNTER_BITS;
   localparam int MUL_STEPS = (TOT_W + CHUNK_W - 1) / CHUNK_W;
   localparam int PAD_W     = MUL_STEPS * CHUNK_W;
   localparam int ACC_W     = PAD_W + SCALE_W;

   // Configuration registers.
   logic [FREQ_W-1:0]  freq_low_ff;
   logic [FREQ_W-1:0]  freq_high_ff;
   logic [PW_W-1:0]    width_min_ff;
   logic [PW_W-1:0]    width_max_ff;
   logic [SCALE_W-1:0] tick_scale_ff;
   logic [NUM_W-1:0]   div_num_ff;

   // Measurement state.
   logic [COUNTER_BITS-1:0] start_ff;
   logic                    parity_ff;
   logic [WRAP_W-1:0]       wrap_ff;

   // Working registers.
   logic [PAD_W-1:0]         total_ff;
   logic [ACC_W-1:0]         acc_ff;
   logic [PW_W-1:0]          pw_ff;
   logic signed [33:0]       prod_ff;
   logic [DVD_W-1:0]         dq_ff;
   logic [DVS_W-1:0]         rem_ff;
   logic [DVS_W-1:0]         dvs_ff;
   logic [FREQ_W-1:0]        freq_ff;

   logic [COUNTER_BITS-1:0]      ts_m;
   logic [COUNTER_BITS-1:0]      diff;
   logic [WRAP_W-1:0]            wraps;
   logic [TOT_W-1:0]             total;
   logic [CHUNK_W+SCALE_W-1:0]   mprod;
   logic [ACC_W-1:0]             acc_in;
   logic [PAD_W-1:0]             acc_hi;
   logic [PW_W-1:0]              pw_in;
   logic                         bad_band;
   logic [PW_W-1:0]              w_clamp;
   logic [PW_W-1:0]              w_off;
   logic signed [16:0]           delta;
   logic signed [33:0]           prod_in;
   logic signed [33:0]           prod_neg;
   logic [DVD_W-1:0]             mag;
   logic [DVS_W:0]               r1;
   logic [DVS_W:0]               r2;
   logic                         ge1;
   logic                         ge2;
   logic [DVS_W-1:0]             r1s;
   logic [DVS_W-1:0]             r2s;
   logic signed [17:0]           q_s;
   logic signed [17:0]           fsum;
   logic [FREQ_W-1:0]            freq_in;
   logic [DVD_W-1:0]             q_dec;
   logic [CMP_W-1:0]             cmp_raw;
   logic                         status_in;

   assign ts_m         = COUNTER_BITS'(req_timestamp[TSU_W-1:0]);
   assign sts.end_edge = req_cmd && !parity_ff;

   // Tick total: a stamp below the start means the last wrap belongs to the difference.
   assign diff  = ts_m - start_ff;
   assign wraps = wrap_ff - WRAP_W'((ts_m < start_ff) && (wrap_ff != '0));
   assign total = {wraps, diff};

   // Multiply the total by the scale one chunk at a time, most significant first.
   assign mprod  = total_ff[PAD_W-1 -: CHUNK_W] * tick_scale_ff;
   assign acc_in = (acc_ff << CHUNK_W) + ACC_W'(mprod);
   assign acc_hi = acc_ff[ACC_W-1:SCALE_W];
   assign pw_in  = (|acc_hi[PAD_W-1:PW_W]) ? {PW_W{1'b1}} : acc_hi[PW_W-1:0];

   assign bad_band = (width_max_ff <= width_min_ff);
   always_comb begin
      if (pw_ff < width_min_ff) begin
         w_clamp = width_min_ff;
      end else if (pw_ff > width_max_ff) begin
         w_clamp = width_max_ff;
      end else begin
         w_clamp = pw_ff;
      end
   end
   assign w_off    = w_clamp - width_min_ff;
   assign delta    = $signed({1'b0, freq_high_ff}) - $signed({1'b0, freq_low_ff});
   assign prod_in  = $signed({1'b0, w_off}) * delta;
   assign prod_neg = -prod_ff;
   assign mag      = prod_ff[33] ? prod_neg[DVD_W-1:0] : prod_ff[DVD_W-1:0];

   // Restoring divider, two quotient bits per cycle.
   always_comb begin
      r1  = {rem_ff, dq_ff[DVD_W-1]};
      ge1 = (r1 >= {1'b0, dvs_ff});
      r1s = ge1 ? DVS_W'(r1 - {1'b0, dvs_ff}) : r1[DVS_W-1:0];
      r2  = {r1s, dq_ff[DVD_W-2]};
      ge2 = (r2 >= {1'b0, dvs_ff});
      r2s = ge2 ? DVS_W'(r2 - {1'b0, dvs_ff}) : r2[DVS_W-1:0];
   end

   // With a valid band the quotient never exceeds the frequency span.
   assign q_s  = prod_ff[33] ? -$signed({2'b00, dq_ff[FREQ_W-1:0]})
                             : $signed({2'b00, dq_ff[FREQ_W-1:0]});
   assign fsum = $signed({2'b00, freq_low_ff}) + q_s;
   always_comb begin
      if (bad_band || fsum[17]) begin
         freq_in = '0;
      end else if (fsum[16]) begin
         freq_in = {FREQ_W{1'b1}};
      end else begin
         freq_in = fsum[FREQ_W-1:0];
      end
   end

   assign q_dec     = dq_ff - 1'b1;
   assign status_in = bad_band || (freq_ff == '0);
   always_comb begin
      if (status_in || dq_ff == '0) begin
         cmp_raw = '0;
      end else if (dq_ff > DVD_W'(2 ** CMP_W)) begin
         cmp_raw = {CMP_W{1'b1}};
      end else begin
         cmp_raw = q_dec[CMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_low_ff   <= RST_FREQ_LOW;
         freq_high_ff  <= RST_FREQ_HIGH;
         width_min_ff  <= RST_WIDTH_MIN;
         width_max_ff  <= RST_WIDTH_MAX;
         tick_scale_ff <= RST_TICK_SCALE;
         div_num_ff    <= RST_DIV_NUM;
      end else if (csr_write) begin
         case (csr_index)
            CSR_FREQ_LOW:   freq_low_ff   <= csr_data[FREQ_W-1:0];
            CSR_FREQ_HIGH:  freq_high_ff  <= csr_data[FREQ_W-1:0];
            CSR_WIDTH_MIN:  width_min_ff  <= csr_data[PW_W-1:0];
            CSR_WIDTH_MAX:  width_max_ff  <= csr_data[PW_W-1:0];
            CSR_TICK_SCALE: tick_scale_ff <= csr_data[SCALE_W-1:0];
            CSR_DIV_NUM:    div_num_ff    <= csr_data[NUM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         parity_ff <= 1'b0;
         wrap_ff   <= '0;
      end else if (cmd.item_load) begin
         if (!req_cmd) begin
            if (wrap_ff != {WRAP_W{1'b1}}) begin
               wrap_ff <= wrap_ff + 1'b1;
            end
         end else if (parity_ff) begin
            start_ff  <= ts_m;
            parity_ff <= 1'b0;
         end else begin
            wrap_ff   <= '0;
            parity_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         total_ff <= PAD_W'(total);
         acc_ff   <= '0;
      end
      if (cmd.mul_step) begin
         acc_ff   <= acc_in;
         total_ff <= total_ff << CHUNK_W;
      end
      if (cmd.pw_load) begin
         pw_ff <= pw_in;
      end
      if (cmd.map_load) begin
         prod_ff <= prod_in;
      end
      if (cmd.div_load_map) begin
         dq_ff  <= mag;
         rem_ff <= '0;
         dvs_ff <= width_max_ff - width_min_ff;
      end
      if (cmd.div_load_cmp) begin
         dq_ff  <= DVD_W'(div_num_ff);
         rem_ff <= '0;
         dvs_ff <= freq_ff;
      end
      if (cmd.div_step) begin
         dq_ff  <= {dq_ff[DVD_W-3:0], ge1, ge2};
         rem_ff <= r2s;
      end
      if (cmd.freq_load) begin
         freq_ff <= freq_in;
      end
      if (cmd.out_load) begin
         rsp_meas_width    <= pw_ff;
         rsp_tone_freq     <= freq_ff;
         rsp_compare_value <= cmp_raw;
         rsp_status        <= status_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/pulse_width_to_tone_divider.sv
// Channel   Dir  Handshake      Payload
// req_chan  in   valid / ready  cmd, timestamp
// rsp_chan  out  valid / ready  meas_width, tone_freq, compare_value, status
// csr_chan  in   valid / ready  index, data (ready is always high)
//
// A wrap event or a start capture is taken in the idle state and gives no result.
// An end capture holds the block busy until its result is loaded: the scale multiply runs
// one 16-bit chunk a cycle, and the two divisions share one restoring divider that retires
// two quotient bits a cycle.
// Reset is synchronous and restores the register defaults and the measurement state.
// A stalled result waits in the output register; the next transaction is taken meanwhile.
`default_nettype none

module pulse_width_to_tone_divider import pwtd_pkg::*; #(
   parameter int COUNTER_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   pwtd_req_if.sink  req_chan,
   pwtd_rsp_if.source rsp_chan,
   pwtd_csr_if.sink  csr_chan
);

   localparam int MUL_STEPS = (WRAP_W + COUNTER_BITS + CHUNK_W - 1) / CHUNK_W;

   pwtd_cmd_type cmd;
   pwtd_sts_type sts;

   assign csr_chan.ready = 1'b1;

   pwtd_ctrl #(
      .MUL_STEPS(MUL_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pwtd_datapath #(
      .COUNTER_BITS(COUNTER_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_cmd           (req_chan.cmd),
      .req_timestamp     (req_chan.timestamp),
      .csr_write         (csr_chan.valid && csr_chan.ready),
      .csr_index         (csr_chan.index),
      .csr_data          (csr_chan.data),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_meas_width    (rsp_chan.meas_width),
      .rsp_tone_freq     (rsp_chan.tone_freq),
      .rsp_compare_value (rsp_chan.compare_value),
      .rsp_status        (rsp_chan.status)
   );

   // An end capture starts a computation, so the next cycle takes no transaction.
   a_busy_after_end: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && sts.end_edge) |=> !req_chan.ready)
      else $error("request taken while a measurement is in progress");

   // A new result never overwrites one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result register overwritten before it was taken");

   // A result flagged good always carries a nonzero tone frequency.
   a_status_freq: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.status) |-> (rsp_chan.tone_freq != '0))
      else $error("good status with zero tone frequency");

   // A result appears only after the controller loads the output register.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.out_load))
      else $error("result valid without an output load");

endmodule

`default_nettype wire
